>>> rtl/cdc_pkg.sv
// Shared types, constants and register codes for the content-defined chunk cutter.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package cdc_pkg;

  // Default sizes of the internal counters
  localparam int OFFSET_BITS_DEF = 48;
  localparam int LENGTH_BITS_DEF = 15;
  localparam int COUNT_BITS_DEF  = 16;

  // Fixed port widths
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 15;
  localparam int MASK_W   = 32;
  localparam int CNT_W    = 16;
  localparam int OUT_OFF_W = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Item queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BND_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd3;

  // Register reset values
  localparam logic [LEN_W-1:0]  MIN_LEN_RST   = 15'd2048;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 15'd16384;
  localparam logic [MASK_W-1:0] BND_MASK_RST  = 32'd8191;
  localparam logic [CNT_W-1:0]  MAX_COUNT_RST = 16'd10000;

  typedef enum logic [1:0] {
    REASON_BOUNDARY = 2'd0,
    REASON_MAX_LEN  = 2'd1,
    REASON_EOS      = 2'd2
  } cut_reason_t;

  typedef struct packed {
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
    logic [MASK_W-1:0] bnd_mask;
    logic [CNT_W-1:0]  max_count;
  } cfg_t;

  // One queued beat after classification
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              flush;
  } item_t;

endpackage

>>> rtl/cdc_front.sv
// Input side of the chunk cutter: takes beats, drops no-op beats, feeds the item queue.
// Depends on cdc_pkg.
module cdc_front (
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [cdc_pkg::BYTE_W-1:0] data_byte,
  input  logic                      byte_valid,
  input  logic                      end_of_stream,
  input  logic                      q_full,
  output logic                      push,
  output cdc_pkg::item_t            push_item
);

  // a beat with neither byte nor flush leaves the state alone
  logic useful;

  assign useful     = byte_valid | end_of_stream;
  assign item_stall = q_full;
  assign push       = item_valid & ~q_full & useful;

  always_comb begin
    push_item.data     = data_byte;
    push_item.has_byte = byte_valid;
    push_item.flush    = end_of_stream;
  end

endmodule

>>> rtl/cdc_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on cdc_pkg.
module cdc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdc_pkg::item_t push_item,
  output logic           full,
  output logic           q_valid,
  output cdc_pkg::item_t q_item,
  input  logic           pop
);

  cdc_pkg::item_t                 mem [cdc_pkg::QUEUE_DEPTH];
  logic [cdc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cdc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cdc_pkg::QCNT_W-1:0]     count;

  assign full    = (count == cdc_pkg::QCNT_W'(cdc_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers wrap on their own: depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= cdc_pkg::QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= cdc_pkg::QPTR_W'(rd_ptr + 1'b1);
      end
      priority if (push && !pop) begin
        count <= cdc_pkg::QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= cdc_pkg::QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

>>> rtl/cdc_back.sv
// Back end of the chunk cutter: rolling hash, length and offset state, cut decision,
// and the result register. Depends on cdc_pkg.
module cdc_back #(
  parameter int OFFSET_BITS = cdc_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = cdc_pkg::LENGTH_BITS_DEF,
  parameter int COUNT_BITS  = cdc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cdc_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  cdc_pkg::item_t                q_item,
  output logic                          pop,
  output logic                          chunk_valid,
  input  logic                          chunk_stall,
  output logic [cdc_pkg::OUT_OFF_W-1:0] chunk_start,
  output logic [cdc_pkg::OUT_OFF_W-1:0] chunk_end,
  output logic [cdc_pkg::CNT_W-1:0]     chunk_number,
  output logic [1:0]                    cut_reason
);

  localparam int LCMP_W = (LENGTH_BITS > cdc_pkg::LEN_W) ? LENGTH_BITS : cdc_pkg::LEN_W;
  localparam int CCMP_W = (COUNT_BITS > cdc_pkg::CNT_W) ? COUNT_BITS : cdc_pkg::CNT_W;

  // h*33 + b mod (2^32 - 1), folded end-around twice
  function automatic logic [31:0] hash_step(input logic [31:0] h,
                                            input logic [7:0] b);
    logic [37:0] prod;
    logic [32:0] s1;
    logic [31:0] s2;
    prod = {6'd0, h} + {1'b0, h, 5'd0} + {30'd0, b};
    s1   = {1'b0, prod[31:0]} + {27'd0, prod[37:32]};
    s2   = s1[31:0] + {31'd0, s1[32]};
    return (s2 == 32'hFFFF_FFFF) ? 32'd0 : s2;
  endfunction

  logic [31:0]            chunk_hash;
  logic [LENGTH_BITS-1:0] chunk_length;
  logic [OFFSET_BITS-1:0] begin_offset;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0]  chunks_emitted;

  logic [31:0]            hash_next;
  logic [LENGTH_BITS-1:0] length_next;
  logic [OFFSET_BITS-1:0] seen_next;
  logic                   limit;
  logic                   emit;
  cdc_pkg::cut_reason_t   reason;

  // result slot free, or being emptied this cycle
  assign pop = q_valid & (~chunk_valid | ~chunk_stall);

  assign limit = (CCMP_W'(chunks_emitted) >= CCMP_W'(cfg.max_count)) ||
                 (chunks_emitted == {COUNT_BITS{1'b1}});

  always_comb begin
    hash_next   = chunk_hash;
    length_next = chunk_length;
    seen_next   = bytes_seen;
    emit        = 1'b0;
    reason      = cdc_pkg::REASON_EOS;
    if (q_item.has_byte) begin
      hash_next   = hash_step(chunk_hash, q_item.data);
      length_next = LENGTH_BITS'(chunk_length + 1'b1);
      seen_next   = OFFSET_BITS'(bytes_seen + 1'b1);
    end
    priority if (q_item.has_byte &&
                 ((LCMP_W'(length_next) >= LCMP_W'(cfg.max_len)) ||
                  (length_next == {LENGTH_BITS{1'b1}}))) begin
      emit   = 1'b1;
      reason = cdc_pkg::REASON_MAX_LEN;
    end else if (q_item.has_byte &&
                 (LCMP_W'(length_next) >= LCMP_W'(cfg.min_len)) &&
                 ((hash_next & cfg.bnd_mask) == 32'd0)) begin
      emit   = 1'b1;
      reason = cdc_pkg::REASON_BOUNDARY;
    end else if (q_item.flush && (length_next != '0)) begin
      emit   = 1'b1;
      reason = cdc_pkg::REASON_EOS;
    end else begin
      emit   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_hash     <= '0;
      chunk_length   <= '0;
      begin_offset   <= '0;
      bytes_seen     <= '0;
      chunks_emitted <= '0;
      chunk_valid    <= 1'b0;
    end else begin
      // held while stalled, refilled by a cut
      chunk_valid <= (chunk_valid & chunk_stall) | (pop & ~limit & emit);
      if (pop && !limit) begin
        bytes_seen <= seen_next;
        if (emit) begin
          chunk_hash     <= '0;
          chunk_length   <= '0;
          begin_offset   <= seen_next;
          chunks_emitted <= COUNT_BITS'(chunks_emitted + 1'b1);
        end else begin
          chunk_hash   <= hash_next;
          chunk_length <= length_next;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (pop && !limit && emit) begin
      chunk_start  <= cdc_pkg::OUT_OFF_W'(begin_offset);
      chunk_end    <= cdc_pkg::OUT_OFF_W'(OFFSET_BITS'(seen_next - 1'b1));
      chunk_number <= cdc_pkg::CNT_W'(COUNT_BITS'(chunks_emitted + 1'b1));
      cut_reason   <= reason;
    end
  end

  a_cut_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !limit && emit) |=> (chunk_valid && chunk_hash == '0 && chunk_length == '0))
    else $error("cut did not clear chunk state or raise a result");

  a_cut_begin: assert property (@(posedge clk) disable iff (rst)
    (pop && !limit && emit) |=> (begin_offset == bytes_seen))
    else $error("next chunk does not begin after the cut");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!pop || limit) |=> ($stable(bytes_seen) && $stable(chunks_emitted)))
    else $error("state moved without a processed item");

  a_reason_code: assert property (@(posedge clk) disable iff (rst)
    chunk_valid |-> (cut_reason == cdc_pkg::REASON_BOUNDARY ||
                     cut_reason == cdc_pkg::REASON_MAX_LEN ||
                     cut_reason == cdc_pkg::REASON_EOS))
    else $error("result carries an undefined cut reason");

endmodule

>>> rtl/content_defined_chunk_cutter.sv
// Top level of the content-defined chunk cutter: configuration registers and the
// front / queue / back assembly. Depends on cdc_pkg, cdc_front, cdc_queue, cdc_back.
//
// The cutter takes one stream beat per clock (byte, byte flag, end-of-stream flag) while
// item_stall is low and emits one result beat per chunk cut: start offset, inclusive end
// offset, one-based chunk number and cut reason (content boundary, maximum length, end of
// stream). Sustained rate is one beat per cycle while no result waits on chunk_stall: the
// back end updates the rolling hash (multiply by 33, add, end-around fold), length and
// offsets for each item. A beat is written into a four-entry queue when it is accepted;
// the back end takes it from the queue, and a cut loads the result register, from which
// the result beat is valid. Input keeps flowing while a result waits on chunk_stall until
// the four queue entries are full; item_stall is also high during reset.
// Beats with neither byte nor flush are dropped at the front.
// Once the chunk count limit is reached all further input is swallowed without result.
// Configuration writes are ready outside reset and belong in idle periods only.

module content_defined_chunk_cutter #(
  parameter int OFFSET_BITS = cdc_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = cdc_pkg::LENGTH_BITS_DEF,
  parameter int COUNT_BITS  = cdc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdc_pkg::CFG_DATA_W-1:0] cfg_data,
  // stream beats
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [cdc_pkg::BYTE_W-1:0]     data_byte,
  input  logic                           byte_valid,
  input  logic                           end_of_stream,
  // chunk results
  output logic                           chunk_valid,
  input  logic                           chunk_stall,
  output logic [cdc_pkg::OUT_OFF_W-1:0]  chunk_start,
  output logic [cdc_pkg::OUT_OFF_W-1:0]  chunk_end,
  output logic [cdc_pkg::CNT_W-1:0]      chunk_number,
  output logic [1:0]                     cut_reason
);

  cdc_pkg::cfg_t  cfg;
  logic           q_full;
  logic           front_hold;
  logic           push;
  cdc_pkg::item_t push_item;
  logic           q_valid;
  cdc_pkg::item_t q_item;
  logic           pop;

  assign cfg_ready = ~rst;

  // no beats taken while in reset
  assign front_hold = q_full | rst;

  // Register file; values are masked to their field widths on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len   <= cdc_pkg::MIN_LEN_RST;
      cfg.max_len   <= cdc_pkg::MAX_LEN_RST;
      cfg.bnd_mask  <= cdc_pkg::BND_MASK_RST;
      cfg.max_count <= cdc_pkg::MAX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cdc_pkg::CFG_MIN_LEN:   cfg.min_len   <= cfg_data[cdc_pkg::LEN_W-1:0];
        cdc_pkg::CFG_MAX_LEN:   cfg.max_len   <= cfg_data[cdc_pkg::LEN_W-1:0];
        cdc_pkg::CFG_BND_MASK:  cfg.bnd_mask  <= cfg_data[cdc_pkg::MASK_W-1:0];
        cdc_pkg::CFG_MAX_COUNT: cfg.max_count <= cfg_data[cdc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify beats
  cdc_front u_front (
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .end_of_stream (end_of_stream),
    .q_full        (front_hold),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  cdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // back: hash, cut decision, result register
  cdc_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .chunk_valid  (chunk_valid),
    .chunk_stall  (chunk_stall),
    .chunk_start  (chunk_start),
    .chunk_end    (chunk_end),
    .chunk_number (chunk_number),
    .cut_reason   (cut_reason)
  );

endmodule
